>>> src/hsv2rgb_pkg.sv
package hsv2rgb_pkg;

  // Color sector index, hue / 43
  typedef logic [2:0] sector_t;

  localparam sector_t SEC_RED_YEL = 3'd0;
  localparam sector_t SEC_YEL_GRN = 3'd1;
  localparam sector_t SEC_GRN_CYN = 3'd2;
  localparam sector_t SEC_CYN_BLU = 3'd3;
  localparam sector_t SEC_BLU_MAG = 3'd4;
  localparam sector_t SEC_MAG_RED = 3'd5;

  localparam int unsigned HueSpan = 43;

  // After sector split: sector, scaled remainder, raw saturation and value
  typedef struct packed {
    logic       grey;
    sector_t    sector;
    logic [7:0] rem;
    logic [7:0] sat;
    logic [7:0] val;
  } split_t;

  // After saturation products: the three multiplier factors (255 - k)
  typedef struct packed {
    logic       grey;
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] f_floor;
    logic [7:0] f_fall;
    logic [7:0] f_rise;
  } factor_t;

  // After value products: the three channel terms
  typedef struct packed {
    logic       grey;
    sector_t    sector;
    logic [7:0] val;
    logic [7:0] t_floor;
    logic [7:0] t_fall;
    logic [7:0] t_rise;
  } term_t;

endpackage

>>> src/hsv2rgb_if.sv
interface hsv2rgb_hsv_if;
  logic       valid;
  logic       ready;
  logic [7:0] hue;
  logic [7:0] saturation;
  logic [7:0] brightness_value;

  modport source (output valid, hue, saturation, brightness_value, input ready);
  modport sink (input valid, hue, saturation, brightness_value, output ready);
endinterface

interface hsv2rgb_rgb_if;
  logic       valid;
  logic       ready;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

>>> src/hsv2rgb_split.sv
module hsv2rgb_split (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                ready_o,
  input  logic [7:0]          hue_i,
  input  logic [7:0]          sat_i,
  input  logic [7:0]          val_i,
  output logic                valid_o,
  input  logic                ready_i,
  output hsv2rgb_pkg::split_t data_o
);

  localparam logic [7:0] Span1 = 8'(hsv2rgb_pkg::HueSpan);
  localparam logic [7:0] Span2 = 8'(2 * hsv2rgb_pkg::HueSpan);
  localparam logic [7:0] Span3 = 8'(3 * hsv2rgb_pkg::HueSpan);
  localparam logic [7:0] Span4 = 8'(4 * hsv2rgb_pkg::HueSpan);
  localparam logic [7:0] Span5 = 8'(5 * hsv2rgb_pkg::HueSpan);

  logic                 valid_q;
  hsv2rgb_pkg::split_t  data_d, data_q;
  hsv2rgb_pkg::sector_t sector;
  logic [7:0]           base;
  logic [5:0]           rem_raw;
  logic [7:0]           diff;

  // Pick the sector by comparing against the sector starts
  always_comb begin
    if (hue_i >= Span5) begin
      sector = hsv2rgb_pkg::SEC_MAG_RED;
      base   = Span5;
    end else if (hue_i >= Span4) begin
      sector = hsv2rgb_pkg::SEC_BLU_MAG;
      base   = Span4;
    end else if (hue_i >= Span3) begin
      sector = hsv2rgb_pkg::SEC_CYN_BLU;
      base   = Span3;
    end else if (hue_i >= Span2) begin
      sector = hsv2rgb_pkg::SEC_GRN_CYN;
      base   = Span2;
    end else if (hue_i >= Span1) begin
      sector = hsv2rgb_pkg::SEC_YEL_GRN;
      base   = Span1;
    end else begin
      sector = hsv2rgb_pkg::SEC_RED_YEL;
      base   = 8'd0;
    end
    diff    = hue_i - base;
    rem_raw = diff[5:0];
  end

  // Scale the remainder by six: 4x + 2x, at most 252
  always_comb begin
    data_d.grey   = (sat_i == 8'd0);
    data_d.sector = sector;
    data_d.rem    = {rem_raw, 2'b00} + {1'b0, rem_raw, 1'b0};
    data_d.sat    = sat_i;
    data_d.val    = val_i;
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  // Load payload only on an accepted request
  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/hsv2rgb_factor.sv
module hsv2rgb_factor (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::split_t  data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::factor_t data_o
);

  logic                 valid_q;
  hsv2rgb_pkg::factor_t data_d, data_q;
  logic [15:0]          prod_fall;
  logic [15:0]          prod_rise;
  logic [7:0]           rem_inv;

  // Saturation times remainder and its complement
  always_comb begin
    rem_inv   = 8'd255 - data_i.rem;
    prod_fall = 16'(data_i.sat) * 16'(data_i.rem);
    prod_rise = 16'(data_i.sat) * 16'(rem_inv);
  end

  // Turn each k into its factor 255 - k
  always_comb begin
    data_d.grey    = data_i.grey;
    data_d.sector  = data_i.sector;
    data_d.val     = data_i.val;
    data_d.f_floor = 8'd255 - data_i.sat;
    data_d.f_fall  = 8'd255 - prod_fall[15:8];
    data_d.f_rise  = 8'd255 - prod_rise[15:8];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/hsv2rgb_scale.sv
module hsv2rgb_scale (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  hsv2rgb_pkg::factor_t data_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output hsv2rgb_pkg::term_t   data_o
);

  logic               valid_q;
  hsv2rgb_pkg::term_t data_d, data_q;
  logic [15:0]        prod_floor;
  logic [15:0]        prod_fall;
  logic [15:0]        prod_rise;

  // Value times each factor, keep the upper byte
  always_comb begin
    prod_floor = 16'(data_i.val) * 16'(data_i.f_floor);
    prod_fall  = 16'(data_i.val) * 16'(data_i.f_fall);
    prod_rise  = 16'(data_i.val) * 16'(data_i.f_rise);

    data_d.grey    = data_i.grey;
    data_d.sector  = data_i.sector;
    data_d.val     = data_i.val;
    data_d.t_floor = prod_floor[15:8];
    data_d.t_fall  = prod_fall[15:8];
    data_d.t_rise  = prod_rise[15:8];
  end

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

>>> src/hsv_to_rgb_8bit.sv
// HSV to RGB pixel converter, 8 bits per channel.
// hsv_i carries one request of hue, saturation and brightness_value; rgb_o
// returns one red, green, blue pixel per request, in request order. Both
// channels use valid/ready; a transfer happens on a clock edge with both high.
// Four register stages: sector split, saturation products, value products,
// channel select into the output register. Throughput is one pixel per
// cycle while rgb_o.ready stays high; the split stage holds one compare
// chain, each product stage one 8x8 multiply level, the output stage the select.
// A saturation of zero yields grey: all three channels equal the value.
// Reset (rst_ni low, asynchronous) empties all stages; no other state exists.
// When the receiver holds rgb_o.ready low, the output register holds its
// pixel and earlier stages keep filling; once all four are full, hsv_i.ready
// drops until the receiver takes the pixel. Nothing is lost or repeated.
module hsv_to_rgb_8bit (
  input  logic   clk_i,
  input  logic   rst_ni,
  hsv2rgb_hsv_if.sink   hsv_i,
  hsv2rgb_rgb_if.source rgb_o
);

  logic                 split_valid, split_ready;
  hsv2rgb_pkg::split_t  split_data;
  logic                 fac_valid, fac_ready;
  hsv2rgb_pkg::factor_t fac_data;
  logic                 term_valid, term_ready;
  hsv2rgb_pkg::term_t   term_data;

  logic       out_valid_q;
  logic [7:0] red_d, green_d, blue_d;
  logic [7:0] red_q, green_q, blue_q;

  hsv2rgb_split u_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (hsv_i.valid),
    .ready_o (hsv_i.ready),
    .hue_i   (hsv_i.hue),
    .sat_i   (hsv_i.saturation),
    .val_i   (hsv_i.brightness_value),
    .valid_o (split_valid),
    .ready_i (split_ready),
    .data_o  (split_data)
  );

  hsv2rgb_factor u_factor (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (split_valid),
    .ready_o (split_ready),
    .data_i  (split_data),
    .valid_o (fac_valid),
    .ready_i (fac_ready),
    .data_o  (fac_data)
  );

  hsv2rgb_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fac_valid),
    .ready_o (fac_ready),
    .data_i  (fac_data),
    .valid_o (term_valid),
    .ready_i (term_ready),
    .data_o  (term_data)
  );

  // Route the terms to channels by sector
  always_comb begin
    if (term_data.grey) begin
      red_d   = term_data.val;
      green_d = term_data.val;
      blue_d  = term_data.val;
    end else begin
      case (term_data.sector)
        hsv2rgb_pkg::SEC_RED_YEL: begin
          red_d   = term_data.val;
          green_d = term_data.t_rise;
          blue_d  = term_data.t_floor;
        end
        hsv2rgb_pkg::SEC_YEL_GRN: begin
          red_d   = term_data.t_fall;
          green_d = term_data.val;
          blue_d  = term_data.t_floor;
        end
        hsv2rgb_pkg::SEC_GRN_CYN: begin
          red_d   = term_data.t_floor;
          green_d = term_data.val;
          blue_d  = term_data.t_rise;
        end
        hsv2rgb_pkg::SEC_CYN_BLU: begin
          red_d   = term_data.t_floor;
          green_d = term_data.t_fall;
          blue_d  = term_data.val;
        end
        hsv2rgb_pkg::SEC_BLU_MAG: begin
          red_d   = term_data.t_rise;
          green_d = term_data.t_floor;
          blue_d  = term_data.val;
        end
        default: begin
          red_d   = term_data.val;
          green_d = term_data.t_floor;
          blue_d  = term_data.t_fall;
        end
      endcase
    end
  end

  // Output register: advance when empty or when the receiver takes the pixel
  assign term_ready = !out_valid_q || rgb_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (term_ready) begin
      out_valid_q <= term_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (term_ready && term_valid) begin
      red_q   <= red_d;
      green_q <= green_d;
      blue_q  <= blue_d;
    end
  end

  assign rgb_o.valid = out_valid_q;
  assign rgb_o.red   = red_q;
  assign rgb_o.green = green_q;
  assign rgb_o.blue  = blue_q;

endmodule

>>> test/testbench.sv
module testbench;

  localparam int unsigned FullScale = 255;
  localparam int unsigned RemStep   = 6;
  localparam int unsigned FracBits  = 8;
  localparam int unsigned RandomReqs = 500;
  localparam int unsigned DrainCycles = 20;

  typedef struct packed {
    logic [7:0] hue;
    logic [7:0] sat;
    logic [7:0] val;
  } hsv_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } pixel_t;

  logic clk;
  logic rst_n;

  hsv2rgb_hsv_if hsv_if ();
  hsv2rgb_rgb_if rgb_if ();

  hsv_to_rgb_8bit dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .hsv_i (hsv_if),
    .rgb_o (rgb_if)
  );

  hsv_req_t    pending_reqs[$];
  pixel_t      expected_pixels[$];
  hsv_req_t    next_req;
  pixel_t      want_pixel;
  int unsigned total_reqs;
  int unsigned accepted_reqs;
  int unsigned issued_reqs;
  int unsigned sink_cycles;
  int unsigned bad_pixels;

  // Scale value down by (255 - k), keeping the integer part of the 8-bit fraction
  function automatic logic [7:0] attenuate(logic [7:0] v, logic [7:0] k);
    int unsigned prod;
    prod = v * (FullScale - k);
    return 8'(prod >> FracBits);
  endfunction

  // Convert one hue, saturation, value request into the pixel it must yield
  function automatic pixel_t hsv_to_pixel(hsv_req_t req);
    pixel_t               px;
    hsv2rgb_pkg::sector_t sec;
    int unsigned          offset;
    logic [7:0]           t_floor;
    logic [7:0]           t_fall;
    logic [7:0]           t_rise;
    if (req.sat == 8'd0) begin
      px = '{red: req.val, green: req.val, blue: req.val};
    end else begin
      sec     = hsv2rgb_pkg::sector_t'(req.hue / hsv2rgb_pkg::HueSpan);
      offset  = (req.hue % hsv2rgb_pkg::HueSpan) * RemStep;
      t_floor = attenuate(req.val, req.sat);
      t_fall  = attenuate(req.val, 8'((req.sat * offset) >> FracBits));
      t_rise  = attenuate(req.val, 8'((req.sat * (FullScale - offset)) >> FracBits));
      case (sec)
        hsv2rgb_pkg::SEC_RED_YEL: px = '{red: req.val, green: t_rise,  blue: t_floor};
        hsv2rgb_pkg::SEC_YEL_GRN: px = '{red: t_fall,  green: req.val, blue: t_floor};
        hsv2rgb_pkg::SEC_GRN_CYN: px = '{red: t_floor, green: req.val, blue: t_rise};
        hsv2rgb_pkg::SEC_CYN_BLU: px = '{red: t_floor, green: t_fall,  blue: req.val};
        hsv2rgb_pkg::SEC_BLU_MAG: px = '{red: t_rise,  green: t_floor, blue: req.val};
        default:                  px = '{red: req.val, green: t_floor, blue: t_fall};
      endcase
    end
    return px;
  endfunction

  task automatic add_req(logic [7:0] h, logic [7:0] s, logic [7:0] v);
    pending_reqs.push_back('{hue: h, sat: s, val: v});
  endtask

  task automatic check_channel(string name, logic [7:0] exp_val, logic [7:0] got_val);
    if (exp_val !== got_val) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
      bad_pixels++;
    end
  endtask

  // Free-running clock, low first so no rising edge falls at time zero
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // Hold reset at the start, with all block inputs known from time zero
  initial begin
    rst_n                   = 1'b0;
    hsv_if.valid            = 1'b0;
    hsv_if.hue              = 8'd0;
    hsv_if.saturation       = 8'd0;
    hsv_if.brightness_value = 8'd0;
    rgb_if.ready            = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
  end

  // Request driver: hold a request until taken, then fetch the next or idle
  always @(posedge clk) begin
    if (!rst_n) begin
      hsv_if.valid <= 1'b0;
    end else if (!hsv_if.valid || hsv_if.ready) begin
      if (pending_reqs.size() != 0 &&
          ((issued_reqs >= 250 && issued_reqs < 400) || $urandom_range(99) >= 17)) begin
        next_req = pending_reqs.pop_front();
        hsv_if.valid            <= 1'b1;
        hsv_if.hue              <= next_req.hue;
        hsv_if.saturation       <= next_req.sat;
        hsv_if.brightness_value <= next_req.val;
        issued_reqs++;
      end else begin
        hsv_if.valid <= 1'b0;
      end
    end
  end

  // Pixel receiver: stall at random, except for one long calm stretch
  always @(posedge clk) begin
    if (!rst_n) begin
      rgb_if.ready <= 1'b0;
    end else begin
      rgb_if.ready <= (sink_cycles >= 300 && sink_cycles < 450) || $urandom_range(99) >= 17;
      sink_cycles++;
    end
  end

  // Monitor: predict on each accepted request, compare each delivered pixel
  always @(posedge clk) begin
    if (rst_n) begin
      if (hsv_if.valid && hsv_if.ready) begin
        expected_pixels.push_back(hsv_to_pixel('{hue: hsv_if.hue, sat: hsv_if.saturation,
                                                 val: hsv_if.brightness_value}));
        accepted_reqs++;
      end
      if (rgb_if.valid && rgb_if.ready) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t: pixel with none expected, expected nothing, got %0d %0d %0d",
                   $time, rgb_if.red, rgb_if.green, rgb_if.blue);
          bad_pixels++;
        end else begin
          want_pixel = expected_pixels.pop_front();
          check_channel("red", want_pixel.red, rgb_if.red);
          check_channel("green", want_pixel.green, rgb_if.green);
          check_channel("blue", want_pixel.blue, rgb_if.blue);
        end
      end
    end
  end

  // Fill the request queue, then drain and report
  initial begin
    int unsigned kind;
    logic [7:0]  edge_vals[4];
    edge_vals     = '{8'd0, 8'd1, 8'd254, 8'd255};
    accepted_reqs = 0;
    issued_reqs   = 0;
    sink_cycles   = 0;
    bad_pixels    = 0;

    // Grey pixels
    add_req(8'd0, 8'd0, 8'd0);
    add_req(8'd255, 8'd0, 8'd255);
    add_req(8'd128, 8'd0, 8'd77);
    // Sector edges at full saturation and value, region 5 reaching hue 255
    add_req(8'd0, 8'd255, 8'd255);
    add_req(8'd42, 8'd255, 8'd255);
    add_req(8'd43, 8'd255, 8'd255);
    add_req(8'd85, 8'd255, 8'd255);
    add_req(8'd86, 8'd255, 8'd255);
    add_req(8'd128, 8'd255, 8'd255);
    add_req(8'd129, 8'd255, 8'd255);
    add_req(8'd171, 8'd255, 8'd255);
    add_req(8'd172, 8'd255, 8'd255);
    add_req(8'd214, 8'd255, 8'd255);
    add_req(8'd215, 8'd255, 8'd255);
    add_req(8'd255, 8'd255, 8'd255);
    // Small saturation, zero value, mid values
    add_req(8'd100, 8'd1, 8'd255);
    add_req(8'd50, 8'd255, 8'd0);
    add_req(8'd20, 8'd128, 8'd200);
    add_req(8'd150, 8'd77, 8'd1);
    add_req(8'd240, 8'd200, 8'd128);

    // Random requests, with extra weight on grey and on field extremes
    for (int i = 0; i < RandomReqs; i++) begin
      kind = $urandom_range(9);
      if (kind == 0) begin
        add_req(8'($urandom_range(255)), 8'd0, 8'($urandom_range(255)));
      end else if (kind == 1) begin
        add_req(edge_vals[$urandom_range(3)], edge_vals[$urandom_range(3)],
                edge_vals[$urandom_range(3)]);
      end else begin
        add_req(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)));
      end
    end
    total_reqs = pending_reqs.size();

    @(posedge rst_n);
    while (accepted_reqs != total_reqs || expected_pixels.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    if (bad_pixels == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Stop a hung run
  initial begin
    #2000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
